@@ design/tng_pkg.sv @@
package tng_pkg;

  localparam int MAX_DIMS_DEF    = 8;
  localparam int VERTEX_BITS_DEF = 32;

  localparam int VTX_W       = 32;
  localparam int RADIX_W     = 16;
  localparam int DIMS_W      = 4;
  localparam int QB_W        = 5;
  localparam int DIM_FIELD_W = 3;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // shifted divisor of the digit divider: power times up to 2^(RADIX_W-1)
  localparam int DS_W   = VTX_W + RADIX_W - 1;
  localparam int PROD_W = VTX_W + RADIX_W;

  localparam int QUEUE_DEPTH = 2;

  // descriptor layout: vertex, kind, undirected, then one slice per dimension
  localparam int DESC_HDR_W = VTX_W + KIND_W + 1;
  localparam int DESC_DIM_W = VTX_W + 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 16'd4;
  localparam logic [DIMS_W-1:0]  DIMS_RESET  = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX      = 2'd0,
    CFG_DIMENSIONS = 2'd1,
    CFG_UNDIRECTED = 2'd2,
    CFG_WRAP       = 2'd3
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE  = 2'd0,
    KIND_NONE  = 2'd1,
    KIND_RANGE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_RANGE,
    F_LOAD,
    F_DIV,
    F_PUSH
  } fstate_t;

  // normalized configuration as seen by the datapath
  typedef struct packed {
    logic [RADIX_W-1:0] radix_n;
    logic [DIMS_W-1:0]  dims;
    logic               undirected;
    logic               wrap;
    logic [QB_W-1:0]    qbits;
  } cfg_t;

  function automatic logic [QB_W-1:0] bit_length(input logic [RADIX_W-1:0] x);
    logic [QB_W-1:0] len;
    len = '0;
    for (int i = 0; i < RADIX_W; i++) begin
      if (x[i]) begin
        len = QB_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

@@ design/tng_if.sv @@
interface tng_in_if;
  logic                        valid;
  logic                        ready;
  logic [tng_pkg::VTX_W-1:0]   vertex_index;

  modport source (output valid, output vertex_index, input ready);
  modport sink   (input valid, input vertex_index, output ready);
endinterface

interface tng_out_if;
  logic                              valid;
  logic                              ready;
  logic [tng_pkg::VTX_W-1:0]         edge_source;
  logic [tng_pkg::VTX_W-1:0]         edge_target;
  logic [tng_pkg::DIM_FIELD_W-1:0]   edge_dimension;
  logic                              is_reverse;
  logic                              is_wrap;
  logic [tng_pkg::KIND_W-1:0]        result_kind;
  logic                              last_of_vertex;

  modport source (output valid, output edge_source, output edge_target,
                  output edge_dimension, output is_reverse, output is_wrap,
                  output result_kind, output last_of_vertex, input ready);
  modport sink   (input valid, input edge_source, input edge_target,
                  input edge_dimension, input is_reverse, input is_wrap,
                  input result_kind, input last_of_vertex, output ready);
endinterface

@@ design/tng_powers.sv @@
module tng_powers #(
  parameter int MAX_DIMS = tng_pkg::MAX_DIMS_DEF,
  localparam int IDX_W = $clog2(MAX_DIMS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [tng_pkg::RADIX_W-1:0]   radix_n,
  input  logic [IDX_W-1:0]              rd_idx,
  output logic [tng_pkg::VTX_W-1:0]     rd_lo,
  output logic                          rd_big,
  output logic                          busy
);

  localparam int VW = tng_pkg::VTX_W;
  localparam int PW = tng_pkg::PROD_W;

  logic             phase;
  logic [IDX_W-1:0] widx;
  logic [VW-1:0]    acc_lo;
  logic [VW-1:0]    acc_hi;
  logic             acc_sat;
  logic [PW-1:0]    prod_lo;

  logic [VW-1:0]    pw_lo  [MAX_DIMS + 1];
  logic             pw_big [MAX_DIMS + 1];

  logic [PW-1:0]    hi_prod;
  logic [PW:0]      hi_sum;
  logic             sat_new;
  logic [VW-1:0]    new_lo;
  logic [VW-1:0]    new_hi;
  logic             new_big;

  // second half of the 64-bit product, carry in from the low half
  always_comb begin
    hi_prod = acc_hi * radix_n;
    hi_sum  = {1'b0, hi_prod} + (PW + 1)'(prod_lo[PW-1:VW]);
    sat_new = acc_sat || (|hi_sum[PW:VW]);
    new_lo  = sat_new ? '1 : prod_lo[VW-1:0];
    new_hi  = sat_new ? '1 : hi_sum[VW-1:0];
    new_big = sat_new || (new_hi != '0);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy    <= 1'b1;
      phase   <= 1'b0;
      widx    <= IDX_W'(1);
      acc_lo  <= VW'(1);
      acc_hi  <= '0;
      acc_sat <= 1'b0;
    end else if (busy) begin
      if (!phase) begin
        prod_lo <= acc_lo * radix_n;
        phase   <= 1'b1;
      end else begin
        phase   <= 1'b0;
        acc_lo  <= new_lo;
        acc_hi  <= new_hi;
        acc_sat <= sat_new;
        widx    <= widx + 1'b1;
        if (widx == IDX_W'(MAX_DIMS)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pw_lo[0]  <= VW'(1);
      pw_big[0] <= 1'b0;
    end else if (busy && phase) begin
      pw_lo[widx]  <= new_lo;
      pw_big[widx] <= new_big;
    end
  end

  assign rd_lo  = pw_lo[rd_idx];
  assign rd_big = pw_big[rd_idx];

endmodule

@@ design/tng_front.sv @@
module tng_front #(
  parameter int MAX_DIMS    = tng_pkg::MAX_DIMS_DEF,
  parameter int VERTEX_BITS = tng_pkg::VERTEX_BITS_DEF,
  localparam int IDX_W  = $clog2(MAX_DIMS + 1),
  localparam int DESC_W = tng_pkg::DESC_HDR_W + MAX_DIMS * tng_pkg::DESC_DIM_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tng_pkg::cfg_t              cfg,
  tng_in_if.sink                     in_ch,
  input  logic                       pw_busy,
  output logic [IDX_W-1:0]           rd_idx,
  input  logic [tng_pkg::VTX_W-1:0]  rd_lo,
  input  logic                       rd_big,
  output logic                       push,
  output logic [DESC_W-1:0]          push_data,
  input  logic                       q_full
);

  localparam int VW   = tng_pkg::VTX_W;
  localparam int RW   = tng_pkg::RADIX_W;
  localparam int DSW  = tng_pkg::DS_W;
  localparam int HW   = tng_pkg::DESC_HDR_W;
  localparam int DW   = tng_pkg::DESC_DIM_W;
  localparam int PW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int K_W  = $clog2(RW);
  localparam logic [VW-1:0] VMASK =
    (VERTEX_BITS >= VW) ? '1 : VW'((64'd1 << VERTEX_BITS) - 64'd1);

  tng_pkg::fstate_t state, state_next;

  logic [VW-1:0]   v;
  tng_pkg::kind_t  kind;
  logic [PW-1:0]   p;
  logic [VW-1:0]   r;
  logic [VW-1:0]   rstart;
  logic [DSW-1:0]  ds;
  logic [RW-1:0]   q;
  logic [K_W-1:0]  k;
  logic [VW-1:0]   dlo;
  logic [VW-1:0]   partner [MAX_DIMS];
  logic            top     [MAX_DIMS];

  logic            ge;
  logic [VW-1:0]   r_sub;
  logic [RW-1:0]   q_new;
  logic [VW-1:0]   dw;
  logic            digit_top;
  logic [VW-1:0]   div_partner;
  logic [VW-1:0]   big_partner;
  logic            out_of_range;
  logic [MAX_DIMS-1:0] emit;
  tng_pkg::kind_t  kind_out;

  // one restoring quotient bit per cycle
  always_comb begin
    ge          = {(DSW - VW)'(0), r} >= ds;
    r_sub       = ge ? (r - ds[VW-1:0]) : r;
    q_new       = {q[RW-2:0], ge};
    dw          = rstart - r_sub;
    digit_top   = (q_new == (cfg.radix_n - 1'b1));
    div_partner = (digit_top ? (v - dw) : (v + dlo)) & VMASK;
    big_partner = (v + rd_lo) & VMASK;
    out_of_range = !rd_big && (v >= rd_lo);
  end

  // classification and descriptor packing
  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      emit[i] = (kind == tng_pkg::KIND_EDGE) && (tng_pkg::DIMS_W'(i) < cfg.dims) &&
                (!top[i] || cfg.wrap);
    end
    if (kind == tng_pkg::KIND_EDGE && emit == '0) begin
      kind_out = tng_pkg::KIND_NONE;
    end else begin
      kind_out = kind;
    end
    push_data = '0;
    push_data[VW-1:0]                = v;
    push_data[VW +: tng_pkg::KIND_W] = kind_out;
    push_data[VW + tng_pkg::KIND_W]  = cfg.undirected;
    for (int i = 0; i < MAX_DIMS; i++) begin
      push_data[HW + i*DW +: VW]  = partner[i];
      push_data[HW + i*DW + VW]   = emit[i];
      push_data[HW + i*DW + VW + 1] = top[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tng_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    push        = 1'b0;
    rd_idx      = IDX_W'(p);
    unique case (state)
      tng_pkg::F_IDLE: begin
        in_ch.ready = !pw_busy;
        if (in_ch.valid && !pw_busy) begin
          state_next = tng_pkg::F_RANGE;
        end
      end
      tng_pkg::F_RANGE: begin
        rd_idx = IDX_W'(cfg.dims);
        state_next = out_of_range ? tng_pkg::F_PUSH : tng_pkg::F_LOAD;
      end
      tng_pkg::F_LOAD: begin
        if (rd_big) begin
          state_next = (p == '0) ? tng_pkg::F_PUSH : tng_pkg::F_LOAD;
        end else begin
          state_next = tng_pkg::F_DIV;
        end
      end
      tng_pkg::F_DIV: begin
        if (k == '0) begin
          state_next = (p == '0) ? tng_pkg::F_PUSH : tng_pkg::F_LOAD;
        end
      end
      tng_pkg::F_PUSH: begin
        push = !q_full;
        if (!q_full) begin
          state_next = tng_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = tng_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      tng_pkg::F_IDLE: begin
        if (in_ch.valid && !pw_busy) begin
          v <= in_ch.vertex_index & VMASK;
        end
      end
      tng_pkg::F_RANGE: begin
        kind <= out_of_range ? tng_pkg::KIND_RANGE : tng_pkg::KIND_EDGE;
        p    <= PW'(cfg.dims - 1'b1);
        r    <= v;
      end
      tng_pkg::F_LOAD: begin
        if (rd_big) begin
          // power beyond the vertex: digit is zero
          top[p]     <= 1'b0;
          partner[p] <= big_partner;
          if (p != '0) begin
            p <= p - 1'b1;
          end
        end else begin
          ds     <= DSW'(rd_lo) << (cfg.qbits - 1'b1);
          q      <= '0;
          k      <= K_W'(cfg.qbits - 1'b1);
          dlo    <= rd_lo;
          rstart <= r;
        end
      end
      tng_pkg::F_DIV: begin
        r  <= r_sub;
        q  <= q_new;
        ds <= ds >> 1;
        k  <= k - 1'b1;
        if (k == '0) begin
          top[p]     <= digit_top;
          partner[p] <= div_partner;
          if (p != '0) begin
            p <= p - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/tng_queue.sv @@
module tng_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rd_data
);

  localparam int DEPTH = tng_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

@@ design/tng_back.sv @@
module tng_back #(
  parameter int MAX_DIMS = tng_pkg::MAX_DIMS_DEF,
  localparam int DESC_W = tng_pkg::DESC_HDR_W + MAX_DIMS * tng_pkg::DESC_DIM_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [DESC_W-1:0] q_data,
  output logic              pop,
  tng_out_if.source         out_ch
);

  localparam int VW = tng_pkg::VTX_W;
  localparam int HW = tng_pkg::DESC_HDR_W;
  localparam int DW = tng_pkg::DESC_DIM_W;
  localparam int PW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic                active;
  logic [DESC_W-1:0]   desc;
  logic [MAX_DIMS-1:0] rem;
  logic                rev;

  logic                ovalid;
  logic [VW-1:0]       o_src;
  logic [VW-1:0]       o_dst;
  logic [tng_pkg::DIM_FIELD_W-1:0] o_dim;
  logic                o_rev;
  logic                o_wrap;
  tng_pkg::kind_t      o_kind;
  logic                o_last;

  logic [PW-1:0]       p_sel;
  logic                more;
  logic [VW-1:0]       v;
  tng_pkg::kind_t      kind;
  logic                und;
  logic [VW-1:0]       partner;
  logic                wbit;
  logic [VW-1:0]       fwd_src;
  logic [VW-1:0]       fwd_dst;
  logic                last;
  logic                adv;
  logic [MAX_DIMS-1:0] rem_load;

  always_comb begin
    p_sel = '0;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        p_sel = PW'(i);
      end
    end
    more    = |(rem & ~(MAX_DIMS'(1) << p_sel));
    v       = desc[VW-1:0];
    kind    = tng_pkg::kind_t'(desc[VW +: tng_pkg::KIND_W]);
    und     = desc[VW + tng_pkg::KIND_W];
    partner = desc[HW + p_sel*DW +: VW];
    wbit    = desc[HW + p_sel*DW + VW + 1];
    // wraparound edges run from the low end of the ring to this vertex
    fwd_src = wbit ? partner : v;
    fwd_dst = wbit ? v : partner;
    last    = (kind != tng_pkg::KIND_EDGE) || (!more && (!und || rev));
    adv     = active && (!ovalid || out_ch.ready);
    pop     = q_valid && (!active || (adv && last));
    for (int i = 0; i < MAX_DIMS; i++) begin
      rem_load[i] = q_data[HW + i*DW + VW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (adv) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (adv && last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc <= q_data;
      rem  <= rem_load;
      rev  <= 1'b0;
    end else if (adv && kind == tng_pkg::KIND_EDGE) begin
      if (und && !rev) begin
        rev <= 1'b1;
      end else begin
        rev        <= 1'b0;
        rem[p_sel] <= 1'b0;
      end
    end
    if (adv) begin
      o_kind <= kind;
      o_last <= last;
      if (kind == tng_pkg::KIND_EDGE) begin
        o_src  <= rev ? fwd_dst : fwd_src;
        o_dst  <= rev ? fwd_src : fwd_dst;
        o_dim  <= tng_pkg::DIM_FIELD_W'(p_sel);
        o_rev  <= rev;
        o_wrap <= wbit;
      end else begin
        o_src  <= v;
        o_dst  <= '0;
        o_dim  <= '0;
        o_rev  <= 1'b0;
        o_wrap <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = ovalid;
  assign out_ch.edge_source    = o_src;
  assign out_ch.edge_target    = o_dst;
  assign out_ch.edge_dimension = o_dim;
  assign out_ch.is_reverse     = o_rev;
  assign out_ch.is_wrap        = o_wrap;
  assign out_ch.result_kind    = o_kind;
  assign out_ch.last_of_vertex = o_last;

endmodule

@@ design/torus_neighbor_edge_generator.sv @@
// Grid neighbor edge generator for a k-ary n-cube (torus or mesh). Each beat on in_ch carries
// one vertex index; out_ch returns its edges in ascending dimension order, each followed by
// its reverse copy when undirected_mode is set, with last_of_vertex on the final beat. An
// index at or beyond radix^dimensions returns one out-of-range beat, and a mesh vertex with
// no edges returns one no-edge beat. A front part range-checks the vertex and extracts its
// base-radix digits with a shared restoring divider, one quotient bit per cycle; a two-entry
// descriptor queue decouples it from the back part, which emits one result per cycle into an
// output register while out_ch is not stalled. The front part takes a new vertex only after
// it has pushed the descriptor of the last one, while the output side delivers one beat per
// cycle when not stalled, up to 2 * dimensions beats per vertex. After reset and after every
// configuration write the table of radix powers is rebuilt, during which in_ch.ready stays
// low. Configuration must only be written while the block is idle.
module torus_neighbor_edge_generator #(
  parameter int MAX_DIMS    = tng_pkg::MAX_DIMS_DEF,
  parameter int VERTEX_BITS = tng_pkg::VERTEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tng_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tng_pkg::CFG_DATA_W-1:0]   cfg_data,
  tng_in_if.sink                           in_ch,
  tng_out_if.source                        out_ch
);

  localparam int IDX_W  = $clog2(MAX_DIMS + 1);
  localparam int DESC_W = tng_pkg::DESC_HDR_W + MAX_DIMS * tng_pkg::DESC_DIM_W;

  // configuration registers
  logic [tng_pkg::RADIX_W-1:0] radix;
  logic [tng_pkg::DIMS_W-1:0]  dimensions;
  logic                        undirected_mode;
  logic                        wrap_mode;

  tng_pkg::cfg_t               cfg;
  logic [tng_pkg::DIMS_W-1:0]  dims_lo;

  // power table read port
  logic [IDX_W-1:0]            rd_idx;
  logic [tng_pkg::VTX_W-1:0]   rd_lo;
  logic                        rd_big;
  logic                        pw_busy;

  // descriptor queue
  logic                        q_push;
  logic [DESC_W-1:0]           q_push_data;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_valid;
  logic [DESC_W-1:0]           q_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix           <= tng_pkg::RADIX_RESET;
      dimensions      <= tng_pkg::DIMS_RESET;
      undirected_mode <= 1'b0;
      wrap_mode       <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (tng_pkg::cfg_reg_t'(cfg_index))
        tng_pkg::CFG_RADIX:      radix           <= cfg_data[tng_pkg::RADIX_W-1:0];
        tng_pkg::CFG_DIMENSIONS: dimensions      <= cfg_data[tng_pkg::DIMS_W-1:0];
        tng_pkg::CFG_UNDIRECTED: undirected_mode <= cfg_data[0];
        tng_pkg::CFG_WRAP:       wrap_mode       <= cfg_data[0];
      endcase
    end
  end

  // radix below two acts as two; dimensions clamp to 1 .. MAX_DIMS
  always_comb begin
    dims_lo        = (dimensions == '0) ? tng_pkg::DIMS_W'(1) : dimensions;
    cfg.radix_n    = (radix < tng_pkg::RADIX_W'(2)) ? tng_pkg::RADIX_W'(2) : radix;
    cfg.dims       = (dims_lo > tng_pkg::DIMS_W'(MAX_DIMS)) ? tng_pkg::DIMS_W'(MAX_DIMS)
                                                            : dims_lo;
    cfg.undirected = undirected_mode;
    cfg.wrap       = wrap_mode;
    // quotient bits per digit
    cfg.qbits      = tng_pkg::bit_length(cfg.radix_n - 1'b1);
  end

  // radix^p for p = 0 .. MAX_DIMS, saturating like a 64-bit product
  tng_powers #(
    .MAX_DIMS (MAX_DIMS)
  ) u_powers (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr_en),
    .radix_n (cfg.radix_n),
    .rd_idx  (rd_idx),
    .rd_lo   (rd_lo),
    .rd_big  (rd_big),
    .busy    (pw_busy)
  );

  // range check, digit extraction and edge classification
  tng_front #(
    .MAX_DIMS    (MAX_DIMS),
    .VERTEX_BITS (VERTEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .pw_busy   (pw_busy),
    .rd_idx    (rd_idx),
    .rd_lo     (rd_lo),
    .rd_big    (rd_big),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  tng_queue #(
    .W (DESC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .rd_data   (q_rd_data)
  );

  // one result beat per cycle from the queued descriptor while out_ch is not stalled
  tng_back #(
    .MAX_DIMS (MAX_DIMS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rd_data),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // no intake while the power table is being rebuilt
  a_no_intake_while_sweeping: assert property (@(posedge clk) disable iff (rst)
    pw_busy |-> !in_ch.ready)
    else $error("input ready during power table rebuild");

  // special results are single, plain and closing
  a_special_result_shape: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.result_kind != tng_pkg::KIND_EDGE) |->
      (out_ch.last_of_vertex && !out_ch.is_reverse && !out_ch.is_wrap &&
       out_ch.edge_target == '0))
    else $error("malformed out-of-range or no-edge result");

  // reverse copies only appear in undirected mode
  a_reverse_needs_undirected: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.is_reverse) |-> cfg.undirected)
    else $error("reverse edge while undirected mode is off");

  // a plain mesh never produces wraparound edges
  a_no_wrap_in_mesh: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !cfg.wrap) |-> !out_ch.is_wrap)
    else $error("wraparound edge in mesh mode");

endmodule

@@ tb/sv/tng_edge_checker.sv @@
`timescale 1ns / 1ps

module tng_edge_checker
  import tng_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tng_in_if                     in_mon,
  tng_out_if                    out_mon,
  output int                    mismatch_count,
  output int                    pending_beats
);

  localparam int GRID_DIMS_MAX = 8;

  typedef struct {
    logic [VTX_W-1:0]       src;
    logic [VTX_W-1:0]       dst;
    logic [DIM_FIELD_W-1:0] dim;
    logic                   rev;
    logic                   wrp;
    kind_t                  kind;
    logic                   last;
  } edge_beat_t;

  logic [RADIX_W-1:0] radix_q;
  logic [DIMS_W-1:0]  dims_q;
  logic               undirected_q;
  logic               wrap_q;

  edge_beat_t expected_edges[$];

  initial begin
    mismatch_count = 0;
    pending_beats  = 0;
  end

  // neighbor edges of one vertex, in ascending dimension order
  task automatic predict_edges(input logic [VTX_W-1:0] vertex);
    longint unsigned n, v, d, src, dst;
    longint unsigned pw[0:GRID_DIMS_MAX];
    int              dims;
    logic            wrp;
    edge_beat_t      beats[$];
    n    = (radix_q < 2) ? 2 : radix_q;
    dims = (dims_q == 0) ? 1 : ((dims_q > GRID_DIMS_MAX) ? GRID_DIMS_MAX : dims_q);
    v    = vertex;
    pw[0] = 1;
    for (int p = 1; p <= dims; p++) begin
      pw[p] = (pw[p-1] > 64'hFFFF_FFFF_FFFF_FFFF / n) ? 64'hFFFF_FFFF_FFFF_FFFF : pw[p-1] * n;
    end
    if (v >= pw[dims]) begin
      expected_edges.push_back('{vertex, '0, '0, 1'b0, 1'b0, KIND_RANGE, 1'b1});
      return;
    end
    for (int p = 0; p < dims; p++) begin
      d = (v / pw[p]) % n;
      if (d < n - 1) begin
        src = v;
        dst = v + pw[p];
        wrp = 1'b0;
      end else if (wrap_q) begin
        src = v - d * pw[p];
        dst = v;
        wrp = 1'b1;
      end else begin
        continue;
      end
      beats.push_back('{src[VTX_W-1:0], dst[VTX_W-1:0], 3'(p), 1'b0, wrp, KIND_EDGE, 1'b0});
      if (undirected_q) begin
        beats.push_back('{dst[VTX_W-1:0], src[VTX_W-1:0], 3'(p), 1'b1, wrp, KIND_EDGE, 1'b0});
      end
    end
    if (beats.size() == 0) begin
      beats.push_back('{vertex, '0, '0, 1'b0, 1'b0, KIND_NONE, 1'b0});
    end
    beats[beats.size()-1].last = 1'b1;
    foreach (beats[i]) expected_edges.push_back(beats[i]);
  endtask

  task automatic check_field(input string name, input logic [VTX_W-1:0] want,
                             input logic [VTX_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    edge_beat_t want;
    if (rst) begin
      radix_q      = RADIX_RESET;
      dims_q       = DIMS_RESET;
      undirected_q = 1'b0;
      wrap_q       = 1'b1;
    end else begin
      if (in_mon.valid && in_mon.ready) predict_edges(in_mon.vertex_index);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_edges.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual src %0h dst %0h kind %0d",
                   $time, out_mon.edge_source, out_mon.edge_target, out_mon.result_kind);
          mismatch_count++;
        end else begin
          want = expected_edges.pop_front();
          check_field("edge_source", want.src, out_mon.edge_source);
          check_field("edge_target", want.dst, out_mon.edge_target);
          check_field("edge_dimension", want.dim, out_mon.edge_dimension);
          check_field("is_reverse", want.rev, out_mon.is_reverse);
          check_field("is_wrap", want.wrp, out_mon.is_wrap);
          check_field("result_kind", want.kind, out_mon.result_kind);
          check_field("last_of_vertex", want.last, out_mon.last_of_vertex);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          CFG_RADIX:      radix_q      = cfg_data[RADIX_W-1:0];
          CFG_DIMENSIONS: dims_q       = cfg_data[DIMS_W-1:0];
          CFG_UNDIRECTED: undirected_q = cfg_data[0];
          CFG_WRAP:       wrap_q       = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending_beats = expected_edges.size();
  end

endmodule

@@ tb/sv/torus_neighbor_edge_generator_test.sv @@
`timescale 1ns / 1ps

module torus_neighbor_edge_generator_test;
  import tng_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tng_in_if  in_ch();
  tng_out_if out_ch();

  int mismatch_count;
  int pending_beats;

  // percentages of cycles in which the sender holds off and the receiver stalls
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  // stimulus-side copy of the grid shape, only used to aim vertex indices
  logic [RADIX_W-1:0] cur_radix = RADIX_RESET;
  logic [DIMS_W-1:0]  cur_dims  = DIMS_RESET;

  torus_neighbor_edge_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tng_edge_checker edge_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending_beats  (pending_beats)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // one vertex beat; returns on the falling edge after acceptance with valid still high,
  // so back-to-back beats never lower and raise valid in the same step
  task automatic send_vertex(input logic [VTX_W-1:0] vertex);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.vertex_index <= vertex;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid, wait for every predicted beat, then let the divider settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (160) @(negedge clk);
  endtask

  // all four registers, only ever with the block drained
  task automatic write_config(input logic [RADIX_W-1:0] radix, input logic [DIMS_W-1:0] dims,
                              input logic undirected, input logic wrap);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_RADIX;
    cfg_data  <= CFG_DATA_W'(radix);
    @(negedge clk);
    cfg_index <= CFG_DIMENSIONS;
    cfg_data  <= CFG_DATA_W'(dims);
    @(negedge clk);
    cfg_index <= CFG_UNDIRECTED;
    cfg_data  <= CFG_DATA_W'(undirected);
    @(negedge clk);
    cfg_index <= CFG_WRAP;
    cfg_data  <= CFG_DATA_W'(wrap);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_radix = radix;
    cur_dims  = dims;
  endtask

  initial begin
    longint unsigned n, span, v;
    longint unsigned pw[0:8];
    int              dims;
    logic [RADIX_W-1:0] radix;

    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_index          = CFG_RADIX;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.vertex_index = '0;
    out_ch.ready       = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // reset shape: 4x4 torus, directed; corners, wrap in both dims, first index out of
    // range and the all-ones index
    send_vertex(32'd0);
    send_vertex(32'd5);
    send_vertex(32'd3);
    send_vertex(32'd12);
    send_vertex(32'd15);
    send_vertex(32'd16);
    send_vertex(32'hFFFF_FFFF);

    // 4x4 mesh, undirected: the far corner has no edges at all
    write_config(16'd4, 4'd2, 1'b1, 1'b0);
    send_vertex(32'd15);
    send_vertex(32'd0);
    send_vertex(32'd7);

    // radix two torus: forward and wraparound edges coincide
    write_config(16'd2, 4'd3, 1'b1, 1'b1);
    send_vertex(32'd0);
    send_vertex(32'd7);
    send_vertex(32'd2);

    // radix zero and zero dimensions fold to radix two, one dimension
    write_config(16'd0, 4'd0, 1'b0, 1'b1);
    send_vertex(32'd0);
    send_vertex(32'd1);
    send_vertex(32'd2);

    // radix one, dims above the maximum saturate: 8-bit hypercube mesh
    write_config(16'd1, 4'd9, 1'b0, 1'b0);
    send_vertex(32'd255);
    send_vertex(32'd256);

    // largest radix, largest dims field: vertex space saturates, up to 16 beats per vertex
    write_config(16'hFFFF, 4'hF, 1'b1, 1'b1);
    send_vertex(32'd0);
    send_vertex(32'hFFFF_FFFF);
    send_vertex(32'd65534);
    send_vertex(32'h8000_0000);

    // largest radix in a 2-d mesh: last in-range index has no edges, next is out of range
    write_config(16'hFFFF, 4'd2, 1'b0, 1'b0);
    send_vertex(32'd4294836224);
    send_vertex(32'd4294836225);

    // 16^8 fills exactly 32 bits: every digit wraps
    write_config(16'd16, 4'd8, 1'b0, 1'b1);
    send_vertex(32'hFFFF_FFFF);

    // ---- random part: 12 shapes, idling style rotates so each appears three times ----
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 5))
        0:       radix = 16'($urandom_range(2, 5));
        1:       radix = 16'($urandom_range(0, 1));
        2:       radix = 16'($urandom_range(6, 20));
        3:       radix = $urandom_range(0, 1) ? 16'd255 : 16'd256;
        4:       radix = 16'($urandom_range(0, 65535));
        default: radix = 16'(65535 - $urandom_range(0, 3));
      endcase
      write_config(radix,
                   ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase

      // vertex space size, capped just above 32 bits
      n    = (cur_radix < 2) ? 2 : cur_radix;
      dims = (cur_dims == 0) ? 1 : ((cur_dims > 8) ? 8 : cur_dims);
      pw[0] = 1;
      for (int p = 1; p <= dims; p++) begin
        pw[p] = (pw[p-1] > 64'h1_0000_0000) ? pw[p-1] : pw[p-1] * n;
      end
      span = (pw[dims] > 64'h1_0000_0000) ? 64'h1_0000_0000 : pw[dims];

      for (int k = 0; k < 22; k++) begin
        case ($urandom_range(0, 9))
          0: v = $urandom;
          1: v = span - 1;
          2: v = span;
          3: begin
            // every digit either zero or radix-1: boundary and wraparound heavy
            v = 0;
            for (int p = 0; p < dims; p++) begin
              if ($urandom_range(0, 1)) v = v + (n - 1) * pw[p];
            end
          end
          default: v = {$urandom, $urandom} % span;
        endcase
        send_vertex(v[VTX_W-1:0]);
      end
    end

    // ---- wrap-up ----
    drain();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tng_pkg.sv
design/tng_if.sv
design/tng_powers.sv
design/tng_front.sv
design/tng_queue.sv
design/tng_back.sv
design/torus_neighbor_edge_generator.sv
tb/sv/tng_edge_checker.sv
tb/sv/torus_neighbor_edge_generator_test.sv
